>>> hw/rtl/fbrd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the FIR beat rate detector.
// No dependencies; every other file of the block but fbrd_ram imports this package.

package fbrd_pkg;

    // Fixed field widths
    localparam int COEF_INDEX_W = 6;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 31;
    localparam int THRESH_W     = 31;
    localparam int REFR_W       = 8;
    localparam int RATE_W       = 16;
    localparam int MIN_BPM_W    = 8;
    localparam int SHIFT_W      = 5;
    localparam int FILT_W       = 16;
    localparam int MAG_W        = 16;
    localparam int SQ_W         = 31;
    localparam int MINPROD_W    = MIN_BPM_W + RATE_W;
    localparam int DIV_CNT_W    = 5;

    // Input beat command codes
    localparam logic CMD_SAMPLE    = 1'b0;
    localparam logic CMD_LOAD_COEF = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_BEAT_THRESHOLD     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REFRACTORY_SAMPLES = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_NUMERATOR     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_BPM            = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_SHIFT       = 3'd4;

    // Register reset values
    localparam logic [THRESH_W-1:0]  RST_BEAT_THRESHOLD     = 31'd300;
    localparam logic [REFR_W-1:0]    RST_REFRACTORY_SAMPLES = 8'd60;
    localparam logic [RATE_W-1:0]    RST_RATE_NUMERATOR     = 16'd7200;
    localparam logic [MIN_BPM_W-1:0] RST_MIN_BPM            = 8'd30;
    localparam logic [SHIFT_W-1:0]   RST_FILTER_SHIFT       = 5'd15;

    // Saturation limits of the filtered value
    localparam logic signed [FILT_W-1:0] FILT_MAX = 16'sh7FFF;
    localparam logic signed [FILT_W-1:0] FILT_MIN = 16'sh8000;

    // Controller to datapath commands
    typedef struct packed {
        logic accept_sample;
        logic accept_coef;
        logic issue;
        logic scale;
        logic square;
        logic detect;
        logic div_start;
        logic out_load;
    } fbrd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic tap_last;
        logic pipe_busy;
        logic rate_ok;
        logic div_done;
        logic out_busy;
    } fbrd_status_t;

endpackage

>>> hw/rtl/fbrd_in_if.sv
`timescale 1ns / 1ps
// Input channel: one beat is a sample or a coefficient load.
// Depends on fbrd_pkg for the coefficient index width.

interface fbrd_in_if #(
    parameter int SAMPLE_BITS = 12,
    parameter int COEF_BITS   = 16
);
    import fbrd_pkg::*;

    logic                                 valid;
    logic                                 ready;
    logic                                 command;
    logic signed [SAMPLE_BITS-1:0]        sample;
    logic        [COEF_INDEX_W-1:0]       coef_index;
    logic signed [COEF_BITS-1:0]          coef_value;

    modport source (output valid, command, sample, coef_index, coef_value, input ready);
    modport sink   (input valid, command, sample, coef_index, coef_value, output ready);
endinterface

>>> hw/rtl/fbrd_out_if.sv
`timescale 1ns / 1ps
// Result channel: filtered level, beat flag and measured rate.
// Depends on fbrd_pkg for field widths.

interface fbrd_out_if;
    import fbrd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [FILT_W-1:0] filtered;
    logic                     beat;
    logic                     rate_valid;
    logic        [RATE_W-1:0] beats_per_minute;

    modport source (output valid, filtered, beat, rate_valid, beats_per_minute, input ready);
    modport sink   (input valid, filtered, beat, rate_valid, beats_per_minute, output ready);
endinterface

>>> hw/rtl/fbrd_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on fbrd_pkg for field widths.

interface fbrd_cfg_if;
    import fbrd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/fbrd_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read.
// No dependencies.

module fbrd_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hw/rtl/fbrd_div.sv
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle.
// Depends on fbrd_pkg for the operand width.

module fbrd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fbrd_pkg::RATE_W-1:0] dividend,
    input  logic [fbrd_pkg::RATE_W-1:0] divisor,
    output logic                        done,
    output logic [fbrd_pkg::RATE_W-1:0] quotient
);
    import fbrd_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [RATE_W-1:0]    rem_reg;
    logic [RATE_W-1:0]    quo_reg;
    logic [RATE_W-1:0]    den_reg;
    logic [RATE_W:0]      shifted;
    logic                 fits;

    // Shift in the next dividend bit and try the subtract
    assign shifted = {rem_reg, quo_reg[RATE_W-1]};
    assign fits    = (shifted >= {1'b0, den_reg});

    // Iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(RATE_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? RATE_W'(shifted - {1'b0, den_reg}) : shifted[RATE_W-1:0];
            quo_reg <= {quo_reg[RATE_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

>>> hw/rtl/fbrd_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the detector: accepts beats and steps the datapath through
// the tap loop, scaling, detection, division and result hand-off. Uses fbrd_pkg.

module fbrd_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    fbrd_in_if.sink                  items,
    output fbrd_pkg::fbrd_cmd_t      cmd,
    input  fbrd_pkg::fbrd_status_t   status
);
    import fbrd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_SCALE,
        S_SQUARE,
        S_DETECT,
        S_DIV_START,
        S_DIVIDE,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   take;

    assign items.ready = (state_reg == S_IDLE);
    assign take        = items.valid && items.ready;

    // Command decode
    always_comb
    begin
        cmd               = '0;
        cmd.accept_sample = take && (items.command == CMD_SAMPLE);
        cmd.accept_coef   = take && (items.command == CMD_LOAD_COEF);
        cmd.issue         = (state_reg == S_MAC);
        cmd.scale         = (state_reg == S_SCALE);
        cmd.square        = (state_reg == S_SQUARE);
        cmd.detect        = (state_reg == S_DETECT);
        cmd.div_start     = (state_reg == S_DIV_START) && status.rate_ok;
        cmd.out_load      = (state_reg == S_FINISH) && !status.out_busy;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept_sample)
                begin
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                if (status.tap_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:     state_next = S_SQUARE;
            S_SQUARE:    state_next = S_DETECT;
            S_DETECT:    state_next = S_DIV_START;
            S_DIV_START: state_next = status.rate_ok ? S_DIVIDE : S_FINISH;
            S_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!status.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

>>> hw/rtl/fbrd_datapath.sv
`timescale 1ns / 1ps
// Datapath: config registers, delay line and coefficient RAMs, serial MAC,
// scaling/saturation, beat detection, rate divider and result register.
// Depends on fbrd_pkg, fbrd_ram, fbrd_div and the result and config channel interfaces.

module fbrd_datapath #(
    parameter int TAPS        = 64,
    parameter int SAMPLE_BITS = 12,
    parameter int COEF_BITS   = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [SAMPLE_BITS-1:0]     sample,
    input  logic [fbrd_pkg::COEF_INDEX_W-1:0] coef_index,
    input  logic signed [COEF_BITS-1:0]       coef_value,
    fbrd_out_if.source                        results,
    fbrd_cfg_if.sink                          cfg,
    input  fbrd_pkg::fbrd_cmd_t               cmd,
    output fbrd_pkg::fbrd_status_t            status
);
    import fbrd_pkg::*;

    localparam int AW      = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CW      = $clog2(TAPS + 1);
    localparam int PW      = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_RAW = PW + $clog2(TAPS);
    localparam int ACC_W   = (ACC_RAW > FILT_W + 1) ? ACC_RAW : FILT_W + 1;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(FILT_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(FILT_MIN);

    // Configuration registers
    logic [THRESH_W-1:0]  beat_threshold_reg;
    logic [REFR_W-1:0]    refractory_samples_reg;
    logic [RATE_W-1:0]    rate_numerator_reg;
    logic [MIN_BPM_W-1:0] min_bpm_reg;
    logic [SHIFT_W-1:0]   filter_shift_reg;

    // Delay line and coefficient bookkeeping
    logic [AW-1:0]   head_reg;
    logic [AW-1:0]   head_next;
    logic [CW-1:0]   fill_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   tap_reg;
    logic [TAPS-1:0] coef_valid_reg;
    logic            coef_in_range;
    logic [AW-1:0]   coef_addr;

    logic [SAMPLE_BITS-1:0] delay_rdata;
    logic [COEF_BITS-1:0]   coef_rdata;

    // MAC pipeline
    logic                          s1_v_reg;
    logic                          s1_dvalid_reg;
    logic                          s1_cvalid_reg;
    logic                          s2_v_reg;
    logic signed [SAMPLE_BITS-1:0] d_op;
    logic signed [COEF_BITS-1:0]   c_op;
    logic signed [PW-1:0]          prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;

    // Scaling, squaring and detection
    logic signed [ACC_W-1:0]  shifted;
    logic signed [FILT_W-1:0] filt_next;
    logic signed [FILT_W-1:0] filt_reg;
    logic [FILT_W:0]          neg_filt;
    logic [MAG_W-1:0]         mag;
    logic [2*MAG_W-1:0]       sq_full;
    logic [SQ_W-1:0]          sq_reg;
    logic [MINPROD_W-1:0]     minprod_reg;
    logic [REFR_W-1:0]        holdoff_reg;
    logic [REFR_W-1:0]        holdoff_next;
    logic [RATE_W-1:0]        interval_reg;
    logic [RATE_W-1:0]        interval_hit;
    logic [RATE_W-1:0]        interval_next;
    logic                     above;
    logic                     beat_next;
    logic                     rate_ok_next;
    logic                     beat_reg;
    logic                     rate_ok_reg;
    logic [RATE_W-1:0]        divisor_reg;

    // Divider and result register
    logic                     div_done;
    logic [RATE_W-1:0]        quotient;
    logic                     out_valid_reg;
    logic signed [FILT_W-1:0] out_filtered_reg;
    logic                     out_beat_reg;
    logic                     out_rate_valid_reg;
    logic [RATE_W-1:0]        out_bpm_reg;

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_threshold_reg     <= RST_BEAT_THRESHOLD;
            refractory_samples_reg <= RST_REFRACTORY_SAMPLES;
            rate_numerator_reg     <= RST_RATE_NUMERATOR;
            min_bpm_reg            <= RST_MIN_BPM;
            filter_shift_reg       <= RST_FILTER_SHIFT;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_BEAT_THRESHOLD:     beat_threshold_reg     <= cfg.data[THRESH_W-1:0];
                CFG_REFRACTORY_SAMPLES: refractory_samples_reg <= cfg.data[REFR_W-1:0];
                CFG_RATE_NUMERATOR:     rate_numerator_reg     <= cfg.data[RATE_W-1:0];
                CFG_MIN_BPM:            min_bpm_reg            <= cfg.data[MIN_BPM_W-1:0];
                CFG_FILTER_SHIFT:       filter_shift_reg       <= cfg.data[SHIFT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Circular delay line: newest sample sits at head, older ones follow upward
    assign head_next     = (head_reg == '0) ? AW'(TAPS - 1) : head_reg - 1'b1;
    assign coef_in_range = (int'(coef_index) < TAPS);
    assign coef_addr     = AW'(coef_index);

    fbrd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TAPS)
    ) u_delay_ram (
        .clk   (clk),
        .we    (cmd.accept_sample),
        .waddr (head_next),
        .wdata (sample),
        .raddr (rd_ptr_reg),
        .rdata (delay_rdata)
    );

    fbrd_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (TAPS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (cmd.accept_coef && coef_in_range),
        .waddr (coef_addr),
        .wdata (coef_value),
        .raddr (tap_reg),
        .rdata (coef_rdata)
    );

    // Pointers, fill count, coefficient valid bits and tap walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            fill_reg       <= '0;
            rd_ptr_reg     <= '0;
            tap_reg        <= '0;
            coef_valid_reg <= '0;
            s1_v_reg       <= 1'b0;
            s2_v_reg       <= 1'b0;
        end
        else
        begin
            s1_v_reg <= cmd.issue;
            s2_v_reg <= s1_v_reg;
            if (cmd.accept_coef && coef_in_range)
            begin
                coef_valid_reg[coef_addr] <= 1'b1;
            end
            if (cmd.accept_sample)
            begin
                head_reg   <= head_next;
                rd_ptr_reg <= head_next;
                tap_reg    <= '0;
                if (fill_reg != CW'(TAPS))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            else if (cmd.issue)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(TAPS - 1)) ? '0 : rd_ptr_reg + 1'b1;
                tap_reg    <= tap_reg + 1'b1;
            end
        end
    end

    assign status.tap_last  = (tap_reg == AW'(TAPS - 1));
    assign status.pipe_busy = s1_v_reg || s2_v_reg;

    // Never-written entries read as zero
    assign d_op = s1_dvalid_reg ? $signed(delay_rdata) : '0;
    assign c_op = s1_cvalid_reg ? $signed(coef_rdata) : '0;

    // Serial MAC: read, multiply, accumulate
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            s1_dvalid_reg <= (CW'(tap_reg) < fill_reg);
            s1_cvalid_reg <= coef_valid_reg[tap_reg];
        end
        if (s1_v_reg)
        begin
            prod_reg <= d_op * c_op;
        end
        if (cmd.accept_sample)
        begin
            acc_reg <= '0;
        end
        else if (s2_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Arithmetic shift (floor) and saturation
    assign shifted = acc_reg >>> filter_shift_reg;

    always_comb
    begin
        if (shifted > SAT_HI)
        begin
            filt_next = FILT_MAX;
        end
        else if (shifted < SAT_LO)
        begin
            filt_next = FILT_MIN;
        end
        else
        begin
            filt_next = FILT_W'(shifted);
        end
    end

    // Magnitude and square
    assign neg_filt = (FILT_W + 1)'(0) - {filt_reg[FILT_W-1], filt_reg};
    assign mag      = filt_reg[FILT_W-1] ? neg_filt[MAG_W-1:0] : MAG_W'(filt_reg);
    assign sq_full  = mag * mag;

    // Beat decision, holdoff and interval update
    always_comb
    begin
        above        = (sq_reg > beat_threshold_reg);
        beat_next    = 1'b0;
        rate_ok_next = 1'b0;
        interval_hit = interval_reg;
        holdoff_next = holdoff_reg;
        if (above)
        begin
            if (holdoff_reg == '0)
            begin
                beat_next    = 1'b1;
                rate_ok_next = (interval_reg != '0) &&
                               (MINPROD_W'(rate_numerator_reg) > minprod_reg);
                interval_hit = RATE_W'(1);
            end
            holdoff_next = refractory_samples_reg;
        end
        else if (holdoff_reg != '0)
        begin
            holdoff_next = holdoff_reg - 1'b1;
        end
        interval_next = (interval_hit == '1) ? interval_hit : interval_hit + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_reg  <= '0;
            interval_reg <= '0;
            rate_ok_reg  <= 1'b0;
        end
        else if (cmd.detect)
        begin
            holdoff_reg  <= holdoff_next;
            interval_reg <= interval_next;
            rate_ok_reg  <= rate_ok_next;
        end
    end

    // Per-sample payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            filt_reg <= filt_next;
        end
        if (cmd.square)
        begin
            sq_reg      <= sq_full[SQ_W-1:0];
            minprod_reg <= min_bpm_reg * interval_reg;
        end
        if (cmd.detect)
        begin
            beat_reg    <= beat_next;
            divisor_reg <= interval_reg;
        end
    end

    assign status.rate_ok = rate_ok_reg;

    fbrd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rate_numerator_reg),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign status.div_done = div_done;

    // Output register; frees while the next sample is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_filtered_reg   <= filt_reg;
            out_beat_reg       <= beat_reg;
            out_rate_valid_reg <= rate_ok_reg;
            out_bpm_reg        <= rate_ok_reg ? quotient : '0;
        end
    end

    assign status.out_busy          = out_valid_reg && !results.ready;
    assign results.valid            = out_valid_reg;
    assign results.filtered         = out_filtered_reg;
    assign results.beat             = out_beat_reg;
    assign results.rate_valid       = out_rate_valid_reg;
    assign results.beats_per_minute = out_bpm_reg;
endmodule

>>> hw/rtl/fir_beat_rate_detector.sv
`timescale 1ns / 1ps
// FIR beat rate detector top level: controller plus datapath.
// A sample beat's result passes through the tap loop, scaling, squaring and detection,
// and through the serial divider as well when a beat yields a rate. A new sample is
// taken only once the last one's result is loaded into the output register; the single
// multiply-accumulate walks one tap per cycle. Coefficient loads keep the controller idle.
// Reset (rst_n, async low): taps read as zero, counters cleared, ready right after reset.

module fir_beat_rate_detector #(
    parameter int TAPS        = 64,
    parameter int SAMPLE_BITS = 12,
    parameter int COEF_BITS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    fbrd_in_if.sink     items,
    fbrd_out_if.source  results,
    fbrd_cfg_if.sink    cfg
);
    import fbrd_pkg::*;

    fbrd_cmd_t    cmd;
    fbrd_status_t status;

    fbrd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .items  (items),
        .cmd    (cmd),
        .status (status)
    );

    fbrd_datapath #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (items.sample),
        .coef_index (items.coef_index),
        .coef_value (items.coef_value),
        .results    (results),
        .cfg        (cfg),
        .cmd        (cmd),
        .status     (status)
    );
endmodule
